@@ rtl/sjfq_pkg.sv @@
// ----------------------------------------------------------------------------
// sjfq_pkg
// shared types and constants of the shortest-job-first queue: transaction
// payloads, operation codes and default sizing
// ----------------------------------------------------------------------------
package sjfq_pkg;

    localparam int DEF_QUEUE_DEPTH = 64;
    localparam int DEF_SIZE_BITS   = 32;

    localparam int JOB_SIZE_W   = 32;
    localparam int FILL_COUNT_W = 7;

    localparam logic MODE_INSERT  = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    typedef struct packed {
        logic                  mode;
        logic [JOB_SIZE_W-1:0] job_size;
    } cmd_t;

    typedef struct packed {
        logic [JOB_SIZE_W-1:0]   out_size;
        logic                    out_valid;
        logic                    was_empty;
        logic                    overflow;
        logic [FILL_COUNT_W-1:0] fill_count;
    } rsp_t;

endpackage

@@ rtl/sjfq_store.sv @@
// ----------------------------------------------------------------------------
// sjfq_store
// sorted size store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module sjfq_store
    import sjfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int SIZE_BITS   = DEF_SIZE_BITS,
    localparam int AW         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
)
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [SIZE_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output logic [SIZE_BITS-1:0] rdata
);

    logic [SIZE_BITS-1:0] mem [QUEUE_DEPTH];
    logic [SIZE_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/sjfq_seq.sv @@
// ----------------------------------------------------------------------------
// sjfq_seq
// operation sequencer: inserts walk the store from the tail with one shared
// compare and one wrapping address adder, moving larger entries up one place
// ----------------------------------------------------------------------------
module sjfq_seq
    import sjfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int SIZE_BITS   = DEF_SIZE_BITS,
    localparam int AW         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int CW         = $clog2(QUEUE_DEPTH + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_acc,
    input  cmd_t                 cmd_in,
    output logic                 idle,
    input  logic                 res_free,
    output logic                 res_push,
    output rsp_t                 res,
    output logic                 mem_we,
    output logic [AW-1:0]        mem_waddr,
    output logic [SIZE_BITS-1:0] mem_wdata,
    output logic                 mem_re,
    output logic [AW-1:0]        mem_raddr,
    input  logic [SIZE_BITS-1:0] mem_rdata
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS_RD  = 3'd1;
    localparam logic [2:0] S_INS_CMP = 3'd2;
    localparam logic [2:0] S_EXT_RD  = 3'd3;
    localparam logic [2:0] S_EXT_CAP = 3'd4;
    localparam logic [2:0] S_RESULT  = 3'd5;

    localparam logic [AW:0] DEPTH_W = (AW + 1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] FULL  = CW'(QUEUE_DEPTH);

    logic [2:0]           state_reg, state_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        k_reg, k_next;
    logic [SIZE_BITS-1:0] size_reg, size_next;
    rsp_t                 res_reg, res_next;

    // shared units
    logic [CW-1:0] offs;
    logic [AW:0]   addr_sum;
    logic [AW-1:0] phys;
    logic          bigger;

    always_comb
    begin
        unique case (state_reg)
            S_INS_RD:  offs = (k_reg == '0) ? '0 : k_reg - CW'(1);
            S_INS_CMP: offs = k_reg;
            S_EXT_CAP: offs = CW'(1);
            default:   offs = '0;
        endcase
    end

    // logical place to physical address, wrapping round the store
    assign addr_sum = {1'b0, head_reg} + (AW + 1)'(offs);
    assign phys     = (addr_sum >= DEPTH_W) ? AW'(addr_sum - DEPTH_W) : AW'(addr_sum);
    assign bigger   = mem_rdata > size_reg;

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        k_next     = k_reg;
        size_next  = size_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = phys;
        mem_wdata  = size_reg;
        mem_re     = 1'b0;
        mem_raddr  = phys;
        res_push   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc)
                begin
                    res_next            = '0;
                    res_next.was_empty  = (count_reg == '0);
                    res_next.fill_count = FILL_COUNT_W'(count_reg);
                    size_next           = SIZE_BITS'(cmd_in.job_size);
                    k_next              = count_reg;
                    if (cmd_in.mode == MODE_INSERT)
                    begin
                        if (count_reg == FULL)
                        begin
                            res_next.overflow = 1'b1;
                            state_next        = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_INS_RD;
                        end
                    end
                    else
                    begin
                        state_next = (count_reg == '0) ? S_RESULT : S_EXT_RD;
                    end
                end
            end
            S_INS_RD:
            begin
                if (k_reg == '0)
                begin
                    // reached the front: new job goes first
                    mem_we              = 1'b1;
                    count_next          = count_reg + CW'(1);
                    res_next.fill_count = FILL_COUNT_W'(count_next);
                    state_next          = S_RESULT;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                mem_we = 1'b1;
                if (bigger)
                begin
                    mem_wdata  = mem_rdata;
                    k_next     = k_reg - CW'(1);
                    state_next = S_INS_RD;
                end
                else
                begin
                    // equal sizes stay ahead of the new job
                    count_next          = count_reg + CW'(1);
                    res_next.fill_count = FILL_COUNT_W'(count_next);
                    state_next          = S_RESULT;
                end
            end
            S_EXT_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_EXT_CAP;
            end
            S_EXT_CAP:
            begin
                head_next           = phys;
                count_next          = count_reg - CW'(1);
                res_next.out_size   = JOB_SIZE_W'(mem_rdata);
                res_next.out_valid  = 1'b1;
                res_next.fill_count = FILL_COUNT_W'(count_next);
                state_next          = S_RESULT;
            end
            S_RESULT:
            begin
                if (res_free)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        size_reg <= size_next;
        res_reg  <= res_next;
    end

    assign idle = (state_reg == S_IDLE);
    assign res  = res_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("entry count beyond queue depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CW'(1) ||
             count_reg == $past(count_reg) - CW'(1)))
        else $error("entry count moved by more than one");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_acc |=> !idle)
        else $error("sequencer idle right after a transaction");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS_RD || state_reg == S_INS_CMP) |-> (k_reg <= count_reg))
        else $error("insert walk outside stored entries");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> res_free)
        else $error("result pushed into an occupied output register");

endmodule

@@ rtl/shortest_job_first_queue.sv @@
// ----------------------------------------------------------------------------
// shortest_job_first_queue
// bounded queue of job sizes kept in ascending order; inserts go behind equal
// sizes, extracts return the smallest job
// ----------------------------------------------------------------------------
// a dropped insert or an empty extract goes straight to the result; an extract
// reads the head and then captures it; an insert reads and compares, one by one,
// each stored entry larger than the new job, shifting it up one place, and then
// writes the new job; the next transaction is taken once the sequencer is back in
// idle, after its result has moved into a free output register
// reset: queue empty, output register empty; the store itself is not cleared
// ----------------------------------------------------------------------------
module shortest_job_first_queue
    import sjfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int SIZE_BITS   = DEF_SIZE_BITS
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic                 seq_idle;
    logic                 cmd_acc;
    logic                 res_free;
    logic                 res_push;
    rsp_t                 res;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [SIZE_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic [SIZE_BITS-1:0] mem_rdata;

    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg;

    assign cmd_stall = !seq_idle;
    assign cmd_acc   = cmd_valid && seq_idle;
    assign res_free  = !rsp_valid_reg || !rsp_stall;

    sjfq_seq #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .SIZE_BITS   (SIZE_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_acc   (cmd_acc),
        .cmd_in    (cmd),
        .idle      (seq_idle),
        .res_free  (res_free),
        .res_push  (res_push),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    sjfq_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .SIZE_BITS   (SIZE_BITS)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register: holds a result until the transaction completes
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_push)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
